// ===== design/assert_macros.svh =====
// Assertion macros shared by the substring search RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SICS_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed: invariant");
// Antecedent in one cycle implies consequent in the next.
`define SICS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define SICS_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define SICS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/sics_pkg.sv =====
// Types, constants and helpers for the substring search block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sics_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_PATTERN_LOW    = 8'd0;
  localparam logic [7:0] CFG_PATTERN_HIGH   = 8'd1;
  localparam logic [7:0] CFG_PATTERN_LENGTH = 8'd2;
  localparam logic [7:0] CFG_MAX_REPORTED   = 8'd3;

  // Result kinds
  localparam logic KIND_POSITION = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  localparam int MAX_TEXT   = 65536;
  localparam int QDEPTH     = 4;
  localparam int QPW        = $clog2(QDEPTH);
  localparam int QCW        = $clog2(QDEPTH + 1);
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic        kind;
    logic [15:0] pos;
    logic [16:0] count;
    logic        last;
  } res_t;

  // Up to two results per transaction, a before b
  typedef struct packed {
    logic a_en;
    logic b_en;
    res_t a;
    res_t b;
  } push_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic [63:0] fold_word(input logic [63:0] w);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i*8 +: 8] = fold_byte(w[i*8 +: 8]);
    end
    return r;
  endfunction

endpackage

// ===== design/sics_in_if.sv =====
// Input channel: text bytes with end-of-text marker.
// No dependencies.
`timescale 1ns / 1ps

interface sics_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

// ===== design/sics_out_if.sv =====
// Result channel: match positions and buffer summaries.
// No dependencies.
`timescale 1ns / 1ps

interface sics_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] match_position;
  logic [16:0] match_count;
  logic        last;

  modport source (output valid, result_kind, match_position, match_count, last,
                  input ready);
  modport sink   (input valid, result_kind, match_position, match_count, last,
                  output ready);
endinterface

// ===== design/sics_cfg_if.sv =====
// Configuration write channel: register index and write data.
// No dependencies.
`timescale 1ns / 1ps

interface sics_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/case_insensitive_substring_search_unit.sv =====
// Top level of the case-insensitive substring search block.
// Depends on sics_pkg, the channel interfaces, sics_cell, sics_outq.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Payload                                            Handshake
// in_chan   in   text_byte[7:0], end_of_text                        valid/ready
// out_chan  out  result_kind, match_position[15:0],
//                match_count[16:0], last                            valid/ready
// cfg_chan  in   index[7:0], data[63:0]                             valid/ready
//
// One text byte per cycle while in_chan is ready. Each result is written into
// the result queue before out_chan shows it. The four-entry result queue sets
// the rate: in_chan is ready while at least two entries are free.
// Reset (rst_n low, synchronous) clears the window, counters and queue;
// no clearing pass. cfg_chan is always ready.
// A stalled out_chan fills the queue and then holds off in_chan.

module case_insensitive_substring_search_unit
  import sics_pkg::*;
#(
  parameter int MAX_PATTERN = 16
)(
  input  logic        clk,
  input  logic        rst_n,
  sics_in_if.sink     in_chan,
  sics_out_if.source  out_chan,
  sics_cfg_if.sink    cfg_chan
);

  // One cell per previous byte the longest pattern needs
  localparam int NCELL = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  // Configuration, pattern kept folded
  logic [127:0] pat_r;
  logic [4:0]   ul_r;        // pattern length in use, 1..MAX_PATTERN
  logic [15:0]  maxrep_r;

  // Per-buffer state
  logic [15:0]  off_r, off_nxt;
  logic [16:0]  found_r, found_nxt, found_hit;
  logic [15:0]  rep_r, rep_nxt;
  logic         stop_r, stop_nxt;

  logic         in_acc, eot, proc, hit, report;
  logic [7:0]   c;
  logic [7:0]   lastp;
  logic [4:0]   cfg_len;

  logic [7:0]       cell_byte [NCELL];
  logic             cell_vld  [NCELL];
  logic [NCELL-1:0] cell_eq;

  push_t          push;
  res_t           head;
  logic [QCW-1:0] q_cnt;
  logic           pop;

  //--------------------------------------------------------------------------
  // Configuration writes
  //--------------------------------------------------------------------------
  assign cfg_chan.ready = 1'b1;

  // zero length means one, anything past the cell row is clamped
  always_comb begin
    cfg_len = cfg_chan.data[4:0];
    if (cfg_len == 5'd0) begin
      cfg_len = 5'd1;
    end else if (cfg_len > 5'(MAX_PATTERN)) begin
      cfg_len = 5'(MAX_PATTERN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r    <= '0;
      ul_r     <= 5'd1;
      maxrep_r <= 16'hFFFF;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_PATTERN_LOW:    pat_r[63:0]   <= fold_word(cfg_chan.data);
        CFG_PATTERN_HIGH:   pat_r[127:64] <= fold_word(cfg_chan.data);
        CFG_PATTERN_LENGTH: ul_r          <= cfg_len;
        CFG_MAX_REPORTED:   maxrep_r      <= cfg_chan.data[15:0];
        default: begin
        end
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Byte intake
  //--------------------------------------------------------------------------
  assign in_chan.ready = (q_cnt <= QCW'(QDEPTH - 2));
  assign in_acc = in_chan.valid && in_chan.ready;
  assign eot    = in_chan.end_of_text;
  assign c      = fold_byte(in_chan.text_byte);
  // zero byte stops the search and never enters the window
  assign proc   = in_acc && !stop_r && (in_chan.text_byte != 8'd0);

  // newest byte is checked against the final pattern byte
  assign lastp = pat_r[{4'(ul_r - 5'd1), 3'b000} +: 8];

  //--------------------------------------------------------------------------
  // Window: cell k holds the byte k+1 places back and checks it against
  // pattern byte ul-2-k. Cells outside the pattern span report agreement.
  //--------------------------------------------------------------------------
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [7:0] tgt;
    logic       care;
    logic [7:0] bin;
    logic       vin;

    assign tgt  = pat_r[{4'(ul_r - 5'd2 - 5'(k)), 3'b000} +: 8];
    assign care = (5'(k + 2) <= ul_r);

    if (k == 0) begin : g_head
      assign bin = c;
      assign vin = 1'b1;
    end else begin : g_body
      assign bin = cell_byte[k-1];
      assign vin = cell_vld[k-1];
    end

    sics_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (in_acc && eot),
      .shift    (proc),
      .byte_in  (bin),
      .vld_in   (vin),
      .tgt      (tgt),
      .care     (care),
      .byte_out (cell_byte[k]),
      .vld_out  (cell_vld[k]),
      .eq       (cell_eq[k])
    );
  end

  assign hit    = proc && (c == lastp) && (&cell_eq);
  assign report = hit && (rep_r < maxrep_r);

  //--------------------------------------------------------------------------
  // Counters; end of text resets them for the next buffer
  //--------------------------------------------------------------------------
  assign found_hit = (hit && found_r != COUNT_MAX) ? found_r + 17'd1 : found_r;

  always_comb begin
    off_nxt   = off_r;
    found_nxt = found_hit;
    rep_nxt   = report ? rep_r + 16'd1 : rep_r;
    stop_nxt  = stop_r;
    if (proc) begin
      off_nxt = off_r + 16'd1;
    end
    if (in_acc && !stop_r &&
        (in_chan.text_byte == 8'd0 || off_r == 16'(MAX_TEXT - 1))) begin
      stop_nxt = 1'b1;
    end
    if (in_acc && eot) begin
      off_nxt   = '0;
      found_nxt = '0;
      rep_nxt   = '0;
      stop_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      found_r <= '0;
      rep_r   <= '0;
      stop_r  <= 1'b0;
    end else begin
      off_r   <= off_nxt;
      found_r <= found_nxt;
      rep_r   <= rep_nxt;
      stop_r  <= stop_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // Results: position first, summary second within one transaction
  //--------------------------------------------------------------------------
  always_comb begin
    push.a_en    = report;
    push.a.kind  = KIND_POSITION;
    push.a.pos   = off_r - 16'(ul_r - 5'd1);
    push.a.count = '0;
    push.a.last  = 1'b0;
    push.b_en    = in_acc && eot;
    push.b.kind  = KIND_SUMMARY;
    push.b.pos   = '0;
    push.b.count = found_hit;
    push.b.last  = 1'b1;
  end

  assign pop = out_chan.valid && out_chan.ready;

  sics_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .cnt   (q_cnt)
  );

  assign out_chan.valid          = (q_cnt != '0);
  assign out_chan.result_kind    = head.kind;
  assign out_chan.match_position = head.pos;
  assign out_chan.match_count    = head.count;
  assign out_chan.last           = head.last;

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  `SICS_ASSERT_ALWAYS(a_q_bound, clk, rst_n, q_cnt <= QCW'(QDEPTH))
  `SICS_ASSERT_ALWAYS(a_rep_le_found, clk, rst_n, {1'b0, rep_r} <= found_r)
  `SICS_ASSERT_NEXT(a_eot_clears, clk, rst_n, in_acc && eot, off_r == '0 && found_r == '0 && !stop_r)

endmodule

// ===== design/sics_cell.sv =====
// One window cell: holds a folded text byte, passes it on, compares it.
// Depends on sics_pkg.
`timescale 1ns / 1ps

module sics_cell
  import sics_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clr,
  input  logic       shift,
  input  logic [7:0] byte_in,
  input  logic       vld_in,
  input  logic [7:0] tgt,
  input  logic       care,
  output logic [7:0] byte_out,
  output logic       vld_out,
  output logic       eq
);

  logic [7:0] byte_r;
  logic       vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (clr) begin
      vld_r <= 1'b0;
    end else if (shift) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign vld_out  = vld_r;
  // cells beyond the pattern span always agree
  assign eq       = !care || (vld_r && (byte_r == tgt));

endmodule

// ===== design/sics_outq.sv =====
// Result queue: takes up to two results per cycle, hands out one.
// Depends on sics_pkg.
`timescale 1ns / 1ps

module sics_outq
  import sics_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  push_t          push,
  input  logic           pop,
  output res_t           head,
  output logic [QCW-1:0] cnt
);

  res_t           q_r [QDEPTH];
  logic [QPW-1:0] wp_r, wp_nxt;
  logic [QPW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r + QPW'(push.a_en) + QPW'(push.b_en);
    rp_nxt  = rp_r + QPW'(pop);
    cnt_nxt = cnt_r + QCW'(push.a_en) + QCW'(push.b_en) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.a_en) begin
      q_r[wp_r] <= push.a;
    end
    if (push.b_en) begin
      q_r[wp_r + QPW'(push.a_en)] <= push.b;
    end
  end

  assign head = q_r[rp_r];
  assign cnt  = cnt_r;

endmodule
